// ===== sv/chte_pkg.sv =====
// Package for the chained hash table engine: sizes, codes and state type.
// Used by chained_hash_table_engine_core, its checker and its testbench.
package chte_pkg;

    localparam int NUM_BUCKETS = 64;
    localparam int NUM_ENTRIES = 256;

    localparam int KEY_W   = 64;
    localparam int DATA_W  = 64;
    localparam int CNT_W   = 7;                          // bucket_count register
    localparam int BKT_W   = $clog2(NUM_BUCKETS);        // bucket index
    localparam int ENT_AW  = $clog2(NUM_ENTRIES);        // entry address
    localparam int PTR_W   = ENT_AW + 1;                 // link incl. null
    localparam int STEP_W  = ENT_AW;                     // chain step counter
    localparam int MOD_BITS  = 4;                        // key bits per cycle
    localparam int MOD_STEPS = KEY_W / MOD_BITS;
    localparam int MODC_W    = $clog2(MOD_STEPS);

    localparam logic [PTR_W-1:0] NIL = PTR_W'(NUM_ENTRIES);
    localparam logic [CNT_W-1:0] BUCKET_COUNT_RST = CNT_W'(NUM_BUCKETS);

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_SEARCH = 2'd1,
        CMD_POP    = 2'd2,
        CMD_NOP    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_FULL  = 2'd1,
        STS_MISS  = 2'd2,
        STS_EMPTY = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MOD,
        ST_INS_RD,
        ST_INS_WR,
        ST_SR_HEAD,
        ST_SR_HCHK,
        ST_SR_RD,
        ST_SR_CHK,
        ST_POP_RD,
        ST_POP_CHK,
        ST_POP_RD2,
        ST_POP_WR,
        ST_DONE
    } t_state;

endpackage

// ===== sv/chte_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module chte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/chained_hash_table_engine_core.sv =====
// Top level of the chained hash table engine: sequencer, modulo unit, memories.
// Depends on chte_pkg and chte_ram.
//
// Channel   Direction  Handshake                Beat
// in        input      i_in_valid / o_in_stall  i_cmd, i_key, i_data_in
// out       output     o_out_valid / i_out_stall o_status, o_data_out
// cfg       input      i_cfg_valid / o_cfg_ready i_cfg_data (bucket_count)
//
// One item at a time. The modulo unit works through the key, 4 key bits a cycle.
// Insert runs it, reads the bucket head and writes the new entry (not when the
// pool is full); search runs it, reads the head, then each chain entry until a
// key match or chain end; pop reads bucket heads in turn and unlinks the first
// entry it finds; the unused command only answers. Reset is synchronous; bucket
// heads read their reset value through one valid bit per bucket, and links
// through a fill count, since fresh entries are first taken in address order, so
// no clearing pass is needed. A result waiting on a stalled output does not
// block the next beat from being taken.
module chained_hash_table_engine_core
    import chte_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_cmd,
    input  logic [KEY_W-1:0]  i_key,
    input  logic [DATA_W-1:0] i_data_in,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [1:0]        o_status,
    output logic [DATA_W-1:0] o_data_out,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CNT_W-1:0]  i_cfg_data
);

    t_state r_state, n_state;

    logic [CNT_W-1:0]  r_bucket_count;
    t_cmd              r_cmd;
    logic [KEY_W-1:0]  r_key, r_sh;
    logic [DATA_W-1:0] r_data;
    logic [CNT_W-1:0]  r_rem, n_rem;
    logic [MODC_W-1:0] r_mcnt;
    logic [BKT_W-1:0]  r_bucket;
    logic [PTR_W-1:0]  r_entry, r_free_head;
    logic [STEP_W-1:0] r_steps;
    t_status           r_res_status;
    logic [DATA_W-1:0] r_res_data;
    logic              r_out_valid;
    t_status           r_out_status;
    logic [DATA_W-1:0] r_out_data;

    logic [NUM_BUCKETS-1:0] r_head_vld;
    logic [PTR_W-1:0]       r_fill;
    logic                   r_hv, r_nv;
    logic [PTR_W-1:0]       r_nrst;

    logic [CNT_W-1:0]  live;
    logic              in_acc, mod_last, out_free, key_hit, chain_end, scan_end;
    logic [PTR_W-1:0]  head_q, next_q, head_val, next_val;
    logic [KEY_W+DATA_W-1:0] kd_q;
    logic              head_we, next_we, kd_we;
    logic [PTR_W-1:0]  head_wdata, next_wdata;

    // Memories: bucket heads, entry links, entry key and data.
    chte_ram #(.WIDTH(PTR_W), .DEPTH(NUM_BUCKETS)) u_head_ram (
        .i_clk  (i_clk),
        .i_we   (head_we),
        .i_waddr(r_bucket),
        .i_wdata(head_wdata),
        .i_raddr(r_bucket),
        .o_rdata(head_q)
    );

    chte_ram #(.WIDTH(PTR_W), .DEPTH(NUM_ENTRIES)) u_next_ram (
        .i_clk  (i_clk),
        .i_we   (next_we),
        .i_waddr(r_entry[ENT_AW-1:0]),
        .i_wdata(next_wdata),
        .i_raddr(r_entry[ENT_AW-1:0]),
        .o_rdata(next_q)
    );

    chte_ram #(.WIDTH(KEY_W + DATA_W), .DEPTH(NUM_ENTRIES)) u_kd_ram (
        .i_clk  (i_clk),
        .i_we   (kd_we),
        .i_waddr(r_entry[ENT_AW-1:0]),
        .i_wdata({r_key, r_data}),
        .i_raddr(r_entry[ENT_AW-1:0]),
        .o_rdata(kd_q)
    );

    // Entries never written since reset read as their reset values.
    assign head_val = r_hv ? head_q : NIL;
    assign next_val = r_nv ? next_q : r_nrst;

    // Effective bucket count: zero reads as one, and it is clamped to the table size.
    always_comb begin
        live = r_bucket_count;
        if (r_bucket_count == '0) begin
            live = CNT_W'(1);
        end else if (r_bucket_count > CNT_W'(NUM_BUCKETS)) begin
            live = CNT_W'(NUM_BUCKETS);
        end
    end

    // Modulo unit: restoring remainder, several key bits per cycle.
    always_comb begin
        logic [CNT_W-1:0] rem;
        rem = r_rem;
        for (int k = 0; k < MOD_BITS; k++) begin
            rem = {rem[CNT_W-2:0], r_sh[KEY_W-1-k]};
            if (rem >= live) begin
                rem = rem - live;
            end
        end
        n_rem = rem;
    end

    assign in_acc    = i_in_valid && !o_in_stall;
    assign mod_last  = (r_mcnt == MODC_W'(MOD_STEPS - 1));
    assign out_free  = !r_out_valid || !i_out_stall;
    assign key_hit   = (kd_q[KEY_W+DATA_W-1:DATA_W] == r_key);
    assign chain_end = (next_val == NIL) || (r_steps == STEP_W'(NUM_ENTRIES - 1));
    assign scan_end  = ((CNT_W'(r_bucket) + CNT_W'(1)) >= live);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    unique case (t_cmd'(i_cmd))
                        CMD_INSERT, CMD_SEARCH: n_state = ST_MOD;
                        CMD_POP:                n_state = ST_POP_RD;
                        CMD_NOP:                n_state = ST_DONE;
                    endcase
                end
            end
            ST_MOD: begin
                if (mod_last) begin
                    if (r_cmd == CMD_SEARCH) begin
                        n_state = ST_SR_HEAD;
                    end else if (r_free_head == NIL) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_INS_RD;
                    end
                end
            end
            ST_INS_RD:  n_state = ST_INS_WR;
            ST_INS_WR:  n_state = ST_DONE;
            ST_SR_HEAD: n_state = ST_SR_HCHK;
            ST_SR_HCHK: n_state = (head_val == NIL) ? ST_DONE : ST_SR_RD;
            ST_SR_RD:   n_state = ST_SR_CHK;
            ST_SR_CHK:  n_state = (key_hit || chain_end) ? ST_DONE : ST_SR_RD;
            ST_POP_RD:  n_state = ST_POP_CHK;
            ST_POP_CHK: begin
                if (head_val != NIL) begin
                    n_state = ST_POP_RD2;
                end else if (scan_end) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_POP_RD;
                end
            end
            ST_POP_RD2: n_state = ST_POP_WR;
            ST_POP_WR:  n_state = ST_DONE;
            ST_DONE:    n_state = out_free ? ST_IDLE : ST_DONE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // Memory write controls.
    always_comb begin
        head_we    = 1'b0;
        next_we    = 1'b0;
        kd_we      = 1'b0;
        head_wdata = next_val;
        next_wdata = r_free_head;
        unique case (r_state)
            ST_INS_WR: begin
                head_we    = 1'b1;
                next_we    = 1'b1;
                kd_we      = 1'b1;
                head_wdata = r_entry;
                next_wdata = head_val;
            end
            ST_POP_WR: begin
                head_we = 1'b1;
                next_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Control state. The fill count marks the entries whose link has been written.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_bucket_count <= BUCKET_COUNT_RST;
            r_free_head    <= '0;
            r_head_vld     <= '0;
            r_fill         <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_bucket_count <= i_cfg_data;
            end
            if (r_state == ST_INS_WR) begin
                r_free_head          <= next_val;
                r_head_vld[r_bucket] <= 1'b1;
                if (r_entry == r_fill) begin
                    r_fill <= r_fill + PTR_W'(1);
                end
            end
            if (r_state == ST_POP_WR) begin
                r_free_head          <= r_entry;
                r_head_vld[r_bucket] <= 1'b1;
            end
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_hv   <= r_head_vld[r_bucket];
        r_nv   <= (r_entry < r_fill);
        r_nrst <= PTR_W'(r_entry[ENT_AW-1:0]) + PTR_W'(1);
        if (in_acc) begin
            r_cmd        <= t_cmd'(i_cmd);
            r_key        <= i_key;
            r_sh         <= i_key;
            r_data       <= i_data_in;
            r_rem        <= '0;
            r_mcnt       <= '0;
            r_bucket     <= '0;
            r_steps      <= '0;
            r_res_status <= (t_cmd'(i_cmd) == CMD_POP) ? STS_EMPTY : STS_OK;
            r_res_data   <= '0;
        end
        unique case (r_state)
            ST_MOD: begin
                r_rem  <= n_rem;
                r_sh   <= r_sh << MOD_BITS;
                r_mcnt <= r_mcnt + MODC_W'(1);
                if (mod_last) begin
                    r_bucket <= n_rem[BKT_W-1:0];
                    r_entry  <= r_free_head;
                    if (r_cmd == CMD_SEARCH) begin
                        r_res_status <= STS_MISS;
                    end else if (r_free_head == NIL) begin
                        r_res_status <= STS_FULL;
                    end
                end
            end
            ST_SR_HCHK: r_entry <= head_val;
            ST_SR_CHK: begin
                if (key_hit) begin
                    r_res_status <= STS_OK;
                    r_res_data   <= kd_q[DATA_W-1:0];
                end else begin
                    r_entry <= next_val;
                    r_steps <= r_steps + STEP_W'(1);
                end
            end
            ST_POP_CHK: begin
                if (head_val != NIL) begin
                    r_entry <= head_val;
                end else begin
                    r_bucket <= r_bucket + BKT_W'(1);
                end
            end
            ST_POP_WR: begin
                r_res_status <= STS_OK;
                r_res_data   <= kd_q[DATA_W-1:0];
            end
            default: begin
            end
        endcase
        if (r_state == ST_DONE && out_free) begin
            r_out_status <= r_res_status;
            r_out_data   <= r_res_data;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_data_out  = r_out_data;
    assign o_cfg_ready = 1'b1;

endmodule

// ===== sv/chte_checker.sv =====
// Port-level checker for the chained hash table engine, bound to the top level.
// Depends on chte_pkg.
module chte_checker
    import chte_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [1:0]        o_status,
    input logic [DATA_W-1:0] o_data_out
);

    // A held result stays until taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_data_out)))
        else $error("result dropped while stalled");

    // Every accepted beat keeps the engine busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("engine took a beat without going busy");

    // Failed operations return zero data.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != STS_OK) |-> (o_data_out == '0))
        else $error("non-zero data on a failed operation");

    // A new result only follows a busy cycle.
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without work");

endmodule

bind chained_hash_table_engine_core chte_checker u_chte_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_stall (o_in_stall),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_status   (o_status),
    .o_data_out (o_data_out)
);

// ===== tb/sv/chained_hash_table_engine_core_test.sv =====
// Self-checking testbench for the chained hash table engine core.
// Depends on chte_pkg and the RTL of chained_hash_table_engine_core.
// Drives insert, search, pop and unused-command beats under random idling and predicts every result.
module chained_hash_table_engine_core_test;
    import chte_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RUN_LIMIT = 5_000_000;
    localparam int DRAIN_CYCLES = 700;

    typedef struct packed {
        t_cmd              cmd;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] data;
    } t_request;

    typedef struct packed {
        t_status           status;
        logic [DATA_W-1:0] data;
    } t_answer;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic [1:0]        i_cmd = 2'd0;
    logic [KEY_W-1:0]  i_key = '0;
    logic [DATA_W-1:0] i_data_in = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [1:0]        o_status;
    logic [DATA_W-1:0] o_data_out;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [CNT_W-1:0]  i_cfg_data = '0;

    chained_hash_table_engine_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_cmd       (i_cmd),
        .i_key       (i_key),
        .i_data_in   (i_data_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_status),
        .o_data_out  (o_data_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // Shadow copy of the table.
    logic [CNT_W-1:0]  shadow_count;
    logic [PTR_W-1:0]  shadow_head [NUM_BUCKETS];
    logic [KEY_W-1:0]  shadow_key  [NUM_ENTRIES];
    logic [DATA_W-1:0] shadow_data [NUM_ENTRIES];
    logic [PTR_W-1:0]  shadow_next [NUM_ENTRIES];
    logic [PTR_W-1:0]  shadow_free;

    t_request   pending_requests[$];
    t_answer    expected_answers[$];
    logic [KEY_W-1:0] key_pool [16];
    int         send_idle_pct = 0;
    int         stall_pct = 0;
    logic       pressure_on = 1'b0;
    logic       hold_done = 1'b0;
    int         hold_left = 0;
    logic       in_taken = 1'b0;
    int         error_count = 0;
    int         cycle_count = 0;

    // Clock generation.
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Effective number of buckets after the zero and saturation rules.
    function automatic int unsigned live_buckets();
        if (shadow_count == 0) return 1;
        if (shadow_count > NUM_BUCKETS) return NUM_BUCKETS;
        return shadow_count;
    endfunction

    // Applies one accepted beat to the shadow table and returns its answer.
    function automatic t_answer apply_request(t_request req);
        t_answer ans;
        logic [PTR_W-1:0] e;
        int unsigned b;
        int unsigned steps;
        ans.status = STS_OK;
        ans.data = '0;
        case (req.cmd)
            CMD_INSERT: begin
                b = int'(req.key % 64'(live_buckets()));
                e = shadow_free;
                if (e >= NUM_ENTRIES) begin
                    ans.status = STS_FULL;
                end else begin
                    shadow_free = shadow_next[e];
                    shadow_key[e] = req.key;
                    shadow_data[e] = req.data;
                    shadow_next[e] = shadow_head[b];
                    shadow_head[b] = e;
                end
            end
            CMD_SEARCH: begin
                e = shadow_head[int'(req.key % 64'(live_buckets()))];
                steps = 0;
                ans.status = STS_MISS;
                while (e < NUM_ENTRIES && steps < NUM_ENTRIES) begin
                    if (shadow_key[e] == req.key) begin
                        ans.status = STS_OK;
                        ans.data = shadow_data[e];
                        break;
                    end
                    e = shadow_next[e];
                    steps++;
                end
            end
            CMD_POP: begin
                ans.status = STS_EMPTY;
                for (b = 0; b < live_buckets(); b++) begin
                    e = shadow_head[b];
                    if (e < NUM_ENTRIES) begin
                        shadow_head[b] = shadow_next[e];
                        shadow_next[e] = shadow_free;
                        shadow_free = e;
                        ans.status = STS_OK;
                        ans.data = shadow_data[e];
                        break;
                    end
                end
            end
            default: begin
            end
        endcase
        return ans;
    endfunction

    // Sender: offers the next beat once the previous one has been taken.
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                t_request req;
                req = pending_requests.pop_front();
                i_in_valid <= 1'b1;
                i_cmd <= req.cmd;
                i_key <= req.key;
                i_data_in <= req.data;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls plus one long hold-off when asked for.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (pressure_on && !hold_done) begin
            hold_left <= 600;
            hold_done <= 1'b1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Monitor: predicts on each accepted input beat, checks each output beat.
    always @(posedge i_clk) begin
        in_taken <= i_in_valid && !o_in_stall;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                t_request req;
                req.cmd = t_cmd'(i_cmd);
                req.key = i_key;
                req.data = i_data_in;
                expected_answers.push_back(apply_request(req));
            end
            if (o_out_valid && !i_out_stall) begin
                if (expected_answers.size() == 0) begin
                    $display("%0t: unexpected result beat status %0d data %h",
                             $time, o_status, o_data_out);
                    error_count++;
                end else begin
                    t_answer want;
                    want = expected_answers.pop_front();
                    if (o_status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, o_status);
                        error_count++;
                    end
                    if (o_data_out !== want.data) begin
                        $display("%0t: data_out expected %h actual %h",
                                 $time, want.data, o_data_out);
                        error_count++;
                    end
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic void queue_request(t_cmd c, logic [63:0] k, logic [63:0] d);
        t_request req;
        req.cmd = c;
        req.key = k;
        req.data = d;
        pending_requests.push_back(req);
    endfunction

    // Waits until every queued beat has been sent and answered.
    task automatic wait_idle();
        while (pending_requests.size() > 0 || i_in_valid || expected_answers.size() > 0)
            @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    // Writes the bucket count register while the block is idle.
    task automatic write_bucket_count(logic [CNT_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        shadow_count = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Random mix over a small key pool so that searches hit and chains grow.
    task automatic queue_random(int count, int insert_pct);
        int r;
        logic [63:0] k;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(99);
            k = ($urandom_range(3) == 0) ? rand64() : key_pool[$urandom_range(15)];
            if (r < insert_pct)
                queue_request(CMD_INSERT, k, rand64());
            else if (r < insert_pct + (100 - insert_pct) * 6 / 10)
                queue_request(CMD_SEARCH, k, rand64());
            else if (r < 96)
                queue_request(CMD_POP, rand64(), rand64());
            else
                queue_request(CMD_NOP, rand64(), rand64());
        end
    endtask

    task automatic set_idling(int mode);
        case (mode)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 73; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 73; end
            default: begin send_idle_pct = 9; stall_pct = 9; end
        endcase
    endtask

    // Stimulus sequence.
    initial begin
        shadow_count = BUCKET_COUNT_RST;
        for (int b = 0; b < NUM_BUCKETS; b++) shadow_head[b] = NIL;
        for (int e = 0; e < NUM_ENTRIES; e++) begin
            shadow_key[e] = '0;
            shadow_data[e] = '0;
            shadow_next[e] = PTR_W'(e + 1);
        end
        shadow_free = '0;
        for (int i = 0; i < 16; i++)
            key_pool[i] = (i < 8) ? 64'($urandom_range(200)) : rand64();

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty table, extreme keys and data, shared buckets, newest wins.
        write_bucket_count(7'd64);
        queue_request(CMD_POP, '1, '1);
        queue_request(CMD_SEARCH, '0, '0);
        queue_request(CMD_INSERT, '0, '1);
        queue_request(CMD_INSERT, '1, '0);
        queue_request(CMD_INSERT, 64'd64, 64'h5555_aaaa_5555_aaaa);
        queue_request(CMD_SEARCH, '0, '0);
        queue_request(CMD_SEARCH, 64'd64, '0);
        queue_request(CMD_SEARCH, '1, '0);
        queue_request(CMD_SEARCH, 64'd128, '0);
        queue_request(CMD_INSERT, 64'd5, 64'haaaa_5555_aaaa_5555);
        queue_request(CMD_INSERT, 64'd5, 64'h1234_5678_9abc_def0);
        queue_request(CMD_SEARCH, 64'd5, '0);
        queue_request(CMD_NOP, '1, '1);
        for (int i = 0; i < 6; i++) queue_request(CMD_POP, rand64(), rand64());
        wait_idle();

        // Random phases over several bucket counts, extremes and out-of-range ones.
        write_bucket_count(7'd1);
        set_idling(0);
        queue_random(100, 45);
        wait_idle();

        write_bucket_count(7'd0);
        set_idling(1);
        queue_random(120, 45);
        wait_idle();

        write_bucket_count(7'd127);
        set_idling(2);
        queue_random(150, 45);
        wait_idle();

        // Count changed with entries stored: some stay stranded until it rises.
        write_bucket_count(7'd7);
        set_idling(3);
        queue_random(150, 40);
        wait_idle();

        // Fill the pool past full under a long receiver hold-off, then drain it.
        write_bucket_count(7'd33);
        set_idling(0);
        pressure_on = 1'b1;
        for (int i = 0; i < 270; i++) queue_request(CMD_INSERT, rand64(), rand64());
        for (int i = 0; i < 20; i++) queue_request(CMD_SEARCH, key_pool[i % 16], '0);
        wait_idle();
        pressure_on = 1'b0;
        write_bucket_count(7'd64);
        set_idling(3);
        for (int i = 0; i < 270; i++) queue_request(CMD_POP, rand64(), rand64());
        wait_idle();

        write_bucket_count(7'd64);
        set_idling(1);
        queue_random(50, 50);
        wait_idle();

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/chte_pkg.sv
sv/chte_ram.sv
sv/chained_hash_table_engine_core.sv
sv/chte_checker.sv
tb/sv/chained_hash_table_engine_core_test.sv
